FILE: hw/rtl/shabsh_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher package
// Payload types, the core control bundle and the SHA-256 constant tables.
// ----------------------------------------------------------------------------
package shabsh_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       no_byte;
    logic       final_item;
  } shabsh_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } shabsh_out_t;

  // Control bundle from the sequencer to the compression core.
  typedef struct packed {
    logic       start;     // begin compressing the block in the window
    logic       init;      // load the initial hash values into the chain
    logic       byte_we;   // write one message byte into the block
    logic [5:0] byte_pos;  // byte position within the 64-byte block
    logic [7:0] byte_val;
  } shabsh_ctl_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_MARK = 8'h80;

endpackage

FILE: hw/rtl/shabsh_compress.sv
// ----------------------------------------------------------------------------
// SHA-256 compression core
// Holds the block/schedule window, the round variables and the chaining
// words. Runs one round per cycle, then folds the round variables into the chain.
// ----------------------------------------------------------------------------
module shabsh_compress
  import shabsh_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  shabsh_ctl_t      ctl,
  output logic             busy,
  output logic [7:0][31:0] chain
);

  // The window holds W[t] .. W[t+15]; it shifts by one word every round.
  logic [31:0] win_r   [16];
  logic [31:0] var_r   [8];
  logic [31:0] chain_r [8];
  logic [5:0]  rnd_r;
  logic        busy_r;
  logic        fold_r;

  logic [31:0] ep0, ep1, maj, chs, t1, t2, sg0, sg1, w_new;

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    ep0   = ror(var_r[0], 2) ^ ror(var_r[0], 13) ^ ror(var_r[0], 22);
    maj   = (var_r[0] & var_r[1]) ^ (var_r[0] & var_r[2]) ^ (var_r[1] & var_r[2]);
    ep1   = ror(var_r[4], 6) ^ ror(var_r[4], 11) ^ ror(var_r[4], 25);
    chs   = (var_r[4] & var_r[5]) ^ (~var_r[4] & var_r[6]);
    t1    = var_r[7] + ep1 + chs + ROUND_K[rnd_r] + win_r[0];
    t2    = ep0 + maj;
    sg0   = ror(win_r[1], 7) ^ ror(win_r[1], 18) ^ (win_r[1] >> 3);
    sg1   = ror(win_r[14], 17) ^ ror(win_r[14], 19) ^ (win_r[14] >> 10);
    w_new = sg1 + win_r[9] + sg0 + win_r[0];
  end

  always_ff @(posedge clk) begin
    if (ctl.byte_we) begin
      win_r[ctl.byte_pos[5:2]][8 * (3 - ctl.byte_pos[1:0]) +: 8] <= ctl.byte_val;
    end else if (busy_r && !fold_r) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i + 1];
      end
      win_r[15] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      for (int i = 0; i < 8; i++) begin
        var_r[i] <= chain_r[i];
      end
    end else if (busy_r && !fold_r) begin
      var_r[7] <= var_r[6];
      var_r[6] <= var_r[5];
      var_r[5] <= var_r[4];
      var_r[4] <= var_r[3] + t1;
      var_r[3] <= var_r[2];
      var_r[2] <= var_r[1];
      var_r[1] <= var_r[0];
      var_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.init) begin
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= INIT_H[i];
      end
    end else if (fold_r) begin
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= chain_r[i] + var_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fold_r <= 1'b0;
      rnd_r  <= '0;
    end else if (ctl.start) begin
      busy_r <= 1'b1;
      fold_r <= 1'b0;
      rnd_r  <= '0;
    end else if (fold_r) begin
      busy_r <= 1'b0;
      fold_r <= 1'b0;
    end else if (busy_r) begin
      rnd_r <= rnd_r + 6'd1;
      if (&rnd_r) begin
        fold_r <= 1'b1;
      end
    end
  end

  assign busy = busy_r;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      chain[i] = chain_r[i];
    end
  end

endmodule

FILE: hw/rtl/sha256_byte_stream_hasher_unit.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Hashes a byte stream and returns the 256-bit digest as eight words.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one transaction per message byte; no_byte marks a
//   transaction without a byte and final_item ends the message. A byte that
//   fills a 64-byte block holds the input while the compression core runs
//   its 64 rounds, folds into the chain and hands back.
//   After the final transaction the sequencer writes the padding and the
//   64-bit bit length one byte per cycle (9 to 72 bytes), compressing each
//   block it fills, then presents the digest as eight output transactions,
//   word 0 first, last_word set on word 7.
//   in_ready is high only while the block is idle; it stays low through
//   padding, compression and digest output. If the receiver stalls, the
//   current digest word holds until taken. After word 7 is taken the block
//   returns to its initial state for the next message.
//   Reset restores the initial hash values and clears the byte count; no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_unit
  import shabsh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  shabsh_in_t  in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output shabsh_out_t out_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_COMP = 2'd1;
  localparam logic [1:0] S_PAD  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  localparam logic [5:0] LEN_POS = 6'd56;

  logic [1:0]  state_r, state_nxt;
  logic [1:0]  ret_r, ret_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [63:0] count_r, count_nxt;
  logic        first_r, first_nxt;
  logic        len_r, len_nxt;
  logic [2:0]  idx_r, idx_nxt;

  shabsh_ctl_t      ctl;
  logic             core_busy;
  logic [7:0][31:0] chain;

  logic        len_phase;
  logic [63:0] bit_len;
  logic [7:0]  len_byte;

  shabsh_compress u_compress (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .busy  (core_busy),
    .chain (chain)
  );

  assign bit_len   = {count_r[60:0], 3'b000};
  assign len_byte  = bit_len[8 * (7 - pos_r[2:0]) +: 8];
  // Length bytes start once the zero fill has reached offset 56.
  assign len_phase = !first_r && (len_r || pos_r == LEN_POS);

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    pos_nxt   = pos_r;
    count_nxt = count_r;
    first_nxt = first_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    ctl       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          first_nxt = 1'b1;
          len_nxt   = 1'b0;
          if (!in_data.no_byte) begin
            ctl.byte_we  = 1'b1;
            ctl.byte_pos = pos_r;
            ctl.byte_val = in_data.data_byte;
            count_nxt    = count_r + 64'd1;
            pos_nxt      = pos_r + 6'd1;
          end
          if (!in_data.no_byte && &pos_r) begin
            ctl.start = 1'b1;
            state_nxt = S_COMP;
            ret_nxt   = in_data.final_item ? S_PAD : S_IDLE;
          end else if (in_data.final_item) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        ctl.byte_we  = 1'b1;
        ctl.byte_pos = pos_r;
        if (first_r) begin
          ctl.byte_val = PAD_MARK;
        end else if (len_phase) begin
          ctl.byte_val = len_byte;
        end else begin
          ctl.byte_val = 8'h00;
        end
        pos_nxt   = pos_r + 6'd1;
        first_nxt = 1'b0;
        if (len_phase) begin
          len_nxt = 1'b1;
        end
        if (&pos_r) begin
          ctl.start = 1'b1;
          state_nxt = S_COMP;
          ret_nxt   = len_phase ? S_OUT : S_PAD;
        end
      end
      S_COMP: begin
        if (!core_busy) begin
          state_nxt = ret_r;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          idx_nxt = idx_r + 3'd1;
          if (&idx_r) begin
            ctl.init  = 1'b1;
            count_nxt = '0;
            pos_nxt   = '0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      pos_r   <= '0;
      count_r <= '0;
      first_r <= 1'b0;
      len_r   <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      pos_r   <= pos_nxt;
      count_r <= count_nxt;
      first_r <= first_nxt;
      len_r   <= len_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    out_data.digest_word = chain[idx_r];
    out_data.word_index  = idx_r;
    out_data.last_word   = &idx_r;
  end

  a_ready_excl_valid: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a digest word is pending");

  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> !core_busy)
    else $error("compression started while the core is busy");

  a_digest_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pos_r == 6'd0))
    else $error("digest presented with a partial block pending");

  a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.last_word) |=> (in_ready && count_r == 64'd0))
    else $error("block not reset after the last digest word");

endmodule

FILE: tb/sha256_byte_stream_hasher_unit_tb.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher testbench
// Sends directed and random messages one byte per transaction. Expected digests
// come from a behavioral SHA-256 or fixed values; each word is checked in order.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_unit_tb;
  import shabsh_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int TOTAL_ITEMS  = 270;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 80;
  localparam int MAX_REPORTS  = 10;

  localparam logic [255:0] EMPTY_DIGEST =
    256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
  localparam logic [255:0] ABC_DIGEST =
    256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

  typedef struct packed {
    shabsh_in_t   item;
    logic         known;
    logic [255:0] digest;
  } stim_row_t;

  localparam int NUM_DIRECTED = 13;
  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    '{'{8'h00, 1'b1, 1'b1}, 1'b1, EMPTY_DIGEST},  // empty message right after reset
    '{'{8'hff, 1'b1, 1'b0}, 1'b0, 256'h0},        // empty transaction, ignored
    '{'{8'hff, 1'b1, 1'b1}, 1'b1, EMPTY_DIGEST},  // byte field ignored on no_byte
    '{'{8'h61, 1'b0, 1'b0}, 1'b0, 256'h0},
    '{'{8'haa, 1'b1, 1'b0}, 1'b0, 256'h0},
    '{'{8'h62, 1'b0, 1'b0}, 1'b0, 256'h0},
    '{'{8'h63, 1'b0, 1'b1}, 1'b1, ABC_DIGEST},
    '{'{8'h00, 1'b0, 1'b1}, 1'b0, 256'h0},
    '{'{8'hff, 1'b0, 1'b1}, 1'b0, 256'h0},
    '{'{8'h80, 1'b0, 1'b0}, 1'b0, 256'h0},
    '{'{8'h7f, 1'b1, 1'b1}, 1'b0, 256'h0},        // message closed by a no-byte end
    '{'{8'h55, 1'b0, 1'b0}, 1'b0, 256'h0},
    '{'{8'haa, 1'b0, 1'b1}, 1'b0, 256'h0}
  };

  localparam int NUM_EDGE_LENS = 10;
  localparam int EDGE_LENS [NUM_EDGE_LENS] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  shabsh_in_t  in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  shabsh_out_t out_data;

  sha256_byte_stream_hasher_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Predictor state: chaining words, the block being filled and the byte count.
  logic [31:0] chain_h [8];
  logic [7:0]  block_buf [64];
  logic [63:0] msg_bytes;
  shabsh_out_t digest_words_q [$];

  int snd_idle_pct   = 23;
  int rcv_idle_pct   = 55;
  bit hold_request   = 1'b0;
  int fail_count     = 0;
  int items_taken    = 0;
  int messages_done  = 0;
  int words_checked  = 0;
  int cycle_count    = 0;
  shabsh_out_t want_word;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void sha_compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1;
    logic [31:0] t2;
    for (int t = 0; t < 16; t++) begin
      w[t] = {block_buf[4*t], block_buf[4*t+1], block_buf[4*t+2], block_buf[4*t+3]};
    end
    for (int t = 16; t < 64; t++) begin
      w[t] = w[t-16] + w[t-7]
           + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
           + (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
    end
    for (int i = 0; i < 8; i++) begin
      v[i] = chain_h[i];
    end
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) begin
      chain_h[i] = chain_h[i] + v[i];
    end
  endfunction

  // Writes one byte into the block and compresses when the block fills.
  function automatic logic [5:0] place_byte(input logic [5:0] pos, input logic [7:0] b);
    block_buf[pos] = b;
    if (pos == 6'd63) sha_compress();
    return pos + 6'd1;
  endfunction

  function automatic void sha_restart();
    for (int i = 0; i < 8; i++) begin
      chain_h[i] = INIT_H[i];
    end
    msg_bytes = '0;
  endfunction

  // Advances the predictor by one transaction; returns 1 when a digest is due.
  function automatic bit sha_absorb(input shabsh_in_t item, output logic [255:0] digest);
    logic [5:0]  pos;
    logic [63:0] bit_len;
    digest = '0;
    if (!item.no_byte) begin
      pos = place_byte(msg_bytes[5:0], item.data_byte);
      msg_bytes = msg_bytes + 64'd1;
    end
    if (!item.final_item) return 1'b0;
    bit_len = msg_bytes << 3;
    pos = place_byte(msg_bytes[5:0], PAD_MARK);
    while (pos != 6'd56) pos = place_byte(pos, 8'h00);
    for (int i = 0; i < 8; i++) begin
      pos = place_byte(pos, bit_len[8*(7-i) +: 8]);
    end
    for (int i = 0; i < 8; i++) begin
      digest = {digest[223:0], chain_h[i]};
    end
    sha_restart();
    return 1'b1;
  endfunction

  function automatic void note_failure(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("ERROR: %s", what);
  endfunction

  task automatic send_item(input shabsh_in_t item, input logic known,
                           input logic [255:0] known_digest);
    logic [255:0] digest;
    shabsh_out_t  word;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_taken++;
    if (sha_absorb(item, digest)) begin
      if (known) digest = known_digest;
      messages_done++;
      for (int i = 0; i < 8; i++) begin
        word.digest_word = digest[255 - 32*i -: 32];
        word.word_index  = 3'(i);
        word.last_word   = (i == 7);
        digest_words_q.push_back(word);
      end
    end
  endtask

  // Mostly short messages, some sized around the padding and block boundaries,
  // with empty transactions scattered in as noise. The length is held to the
  // remaining budget so the run ends close to the planned transaction count.
  task automatic send_random_message(input int budget);
    int         len;
    bit         marker_end;
    shabsh_in_t item;
    if ($urandom_range(99) < 70) len = $urandom_range(12);
    else len = EDGE_LENS[$urandom_range(NUM_EDGE_LENS - 1)];
    if (len > budget) len = budget;
    marker_end = (len == 0) || ($urandom_range(3) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) begin
        item.data_byte  = 8'($urandom_range(255));
        item.no_byte    = 1'b1;
        item.final_item = 1'b0;
        send_item(item, 1'b0, '0);
      end
      item.data_byte  = 8'($urandom_range(255));
      item.no_byte    = 1'b0;
      item.final_item = !marker_end && (i == len - 1);
      send_item(item, 1'b0, '0);
    end
    if (marker_end) begin
      item.data_byte  = 8'($urandom_range(255));
      item.no_byte    = 1'b1;
      item.final_item = 1'b1;
      send_item(item, 1'b0, '0);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off when requested.
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) begin
          @(posedge clk);
        end
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (digest_words_q.size() == 0) begin
        note_failure($sformatf("unexpected digest word %h index %0d last %0b",
                               out_data.digest_word, out_data.word_index, out_data.last_word));
      end else begin
        want_word = digest_words_q.pop_front();
        words_checked++;
        if (out_data.digest_word !== want_word.digest_word)
          note_failure($sformatf("digest_word exp %h got %h (index %0d)",
                                 want_word.digest_word, out_data.digest_word,
                                 want_word.word_index));
        if (out_data.word_index !== want_word.word_index)
          note_failure($sformatf("word_index exp %0d got %0d",
                                 want_word.word_index, out_data.word_index));
        if (out_data.last_word !== want_word.last_word)
          note_failure($sformatf("last_word exp %0b got %0b (index %0d)",
                                 want_word.last_word, out_data.last_word,
                                 want_word.word_index));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d digest words outstanding",
               cycle_count, digest_words_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    bit hold_issued;
    hold_issued = 1'b0;
    sha_restart();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int r = 0; r < NUM_DIRECTED; r++) begin
      send_item(DIRECTED[r].item, DIRECTED[r].known, DIRECTED[r].digest);
    end
    while (items_taken < TOTAL_ITEMS) begin
      if (items_taken >= 2 * TOTAL_ITEMS / 3) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        if (!hold_issued) begin
          hold_issued  = 1'b1;
          hold_request = 1'b1;
        end
      end else if (items_taken >= TOTAL_ITEMS / 3) begin
        snd_idle_pct = 55;
        rcv_idle_pct = 23;
      end
      send_random_message(TOTAL_ITEMS - items_taken);
    end
    in_valid <= 1'b0;
    while (digest_words_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Hashed %0d messages from %0d input transactions, %0d digest words checked.",
             messages_done, items_taken, words_checked);
    $display("Included empty messages, no-byte endings, padding at block edges and a long stall.");
    if (fail_count == 0 && digest_words_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d failures", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
